### hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the double-ended queue with k-th read.
package deq_pkg;

  localparam int DEPTH_DEF = 16;

  // Command codes
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_KTH        = 3'd4;
  localparam logic [2:0] CMD_REVERSE    = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;
  localparam logic [1:0] ERR_POS   = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [4:0]         position;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         error;
    logic [4:0]         occupancy;
  } rsp_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic shift_up;  // every word moves one cell away from cell 0
    logic shift_dn;  // every word moves one cell toward cell 0
    logic write;     // the cell at the write index loads the fill word
  } ctrl_t;

endpackage

### hw/rtl/double_ended_queue_with_kth.sv
`timescale 1ns / 1ps
// Top level of the bounded double-ended queue with k-th-from-back read.
//
// Usage:
//   Commands arrive on cmd (cmd_valid/cmd_ready); each one yields exactly one
//   response on rsp (rsp_valid/rsp_ready) carrying data, error and occupancy.
//   Words live left-justified in a row of DEPTH cells: cell 0 is the physical
//   front. A push or pop at the front shifts the whole row by one cell, a push
//   at the back writes the cell at the current count.
//   Response path and throughput:
//     - push, pop at the physical front, reverse, errors and unused codes:
//       response registered at the transfer edge, one command per cycle.
//     - pop at the physical back and an in-range k-th read: the word is
//       fetched through the registered read chain that runs along the cells,
//       one cell per cycle; the response is registered once the chain has
//       run its full length, and no command is taken while it runs.
//   Stall: the response register holds its transfer until rsp_ready; a new
//   command is taken in the same cycle the old response drains.
//   Reset (rst, synchronous): count, head order flag and handshake state are
//   cleared; stored words are not cleared and are never read before written.
module double_ended_queue_with_kth #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  deq_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output deq_pkg::rsp_t rsp
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SWEEP = 2'b10
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic           rev, rev_next;
  logic [CW-1:0]  sweep_cnt, sweep_cnt_next;
  logic           pend_pop, pend_pop_next;
  logic [IW-1:0]  rd_index, rd_index_next;
  logic           rsp_valid_next;
  deq_pkg::rsp_t  rsp_next;

  deq_pkg::ctrl_t ctrl;
  logic [IW-1:0]  wr_index;
  logic [31:0]    word [DEPTH];
  logic [31:0]    coll [DEPTH];

  logic           cmd_fire;
  logic           full, empty;
  logic [PW-1:0]  pos_w, cnt_w;

  assign cmd_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pos_w     = PW'(cmd.position);
  assign cnt_w     = PW'(count);

  // ---------------------------------------------------------------------
  // Row of cells
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_w, right_w, coll_w;
    if (i == 0) begin : g_first
      assign left_w = cmd.value;
      assign coll_w = '0;
    end else begin : g_mid
      assign left_w = word[i-1];
      assign coll_w = coll[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = word[i];
    end else begin : g_inner
      assign right_w = word[i+1];
    end

    deq_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_index   (wr_index),
      .rd_index   (rd_index),
      .fill       (cmd.value),
      .left_word  (left_w),
      .right_word (right_w),
      .coll_in    (coll_w),
      .word       (word[i]),
      .coll_out   (coll[i])
    );
  end

  // ---------------------------------------------------------------------
  // Command decode and control
  // ---------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    count_next     = count;
    rev_next       = rev;
    sweep_cnt_next = sweep_cnt;
    pend_pop_next  = pend_pop;
    rd_index_next  = rd_index;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    ctrl           = '0;
    wr_index       = IW'(count);

    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          rsp_next.data  = '0;
          rsp_next.error = deq_pkg::ERR_OK;
          rsp_valid_next = 1'b1;
          case (cmd.command)
            deq_pkg::CMD_PUSH_BACK, deq_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                rsp_next.error = deq_pkg::ERR_FULL;
              end else begin
                // logical end mapped to a physical end by the order flag
                if ((cmd.command == deq_pkg::CMD_PUSH_BACK) != rev) begin
                  ctrl.write = 1'b1;
                end else begin
                  ctrl.shift_up = 1'b1;
                end
                count_next = CW'(count + 1'b1);
              end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
              if (empty) begin
                rsp_next.error = deq_pkg::ERR_EMPTY;
              end else if ((cmd.command == deq_pkg::CMD_POP_FRONT) != rev) begin
                rsp_next.data = $signed(word[0]);
                ctrl.shift_dn = 1'b1;
                count_next    = CW'(count - 1'b1);
              end else begin
                // physical back sits at cell count-1: fetch it via the chain
                rsp_valid_next = 1'b0;
                rd_index_next  = IW'(count - 1'b1);
                pend_pop_next  = 1'b1;
                sweep_cnt_next = CW'(DEPTH);
                state_next     = S_SWEEP;
              end
            end
            deq_pkg::CMD_KTH: begin
              if (empty) begin
                rsp_next.error = deq_pkg::ERR_EMPTY;
              end else if ((pos_w == '0) || (pos_w > cnt_w)) begin
                rsp_next.error = deq_pkg::ERR_POS;
              end else begin
                rsp_valid_next = 1'b0;
                rd_index_next  = rev ? IW'(pos_w - 1'b1) : IW'(cnt_w - pos_w);
                pend_pop_next  = 1'b0;
                sweep_cnt_next = CW'(DEPTH);
                state_next     = S_SWEEP;
              end
            end
            deq_pkg::CMD_REVERSE: begin
              rev_next = !rev;
            end
            default: begin
            end
          endcase
          rsp_next.occupancy = 5'(count_next);
        end
      end
      S_SWEEP: begin
        if (sweep_cnt == '0) begin
          // last cell of the chain now holds the selected word
          if (pend_pop) begin
            count_next = CW'(count - 1'b1);
          end
          rsp_next.data      = $signed(coll[DEPTH-1]);
          rsp_next.error     = deq_pkg::ERR_OK;
          rsp_next.occupancy = 5'(count_next);
          rsp_valid_next     = 1'b1;
          state_next         = S_IDLE;
        end else begin
          sweep_cnt_next = CW'(sweep_cnt - 1'b1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rev       <= 1'b0;
      rsp_valid <= 1'b0;
      sweep_cnt <= '0;
      pend_pop  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rev       <= rev_next;
      rsp_valid <= rsp_valid_next;
      sweep_cnt <= sweep_cnt_next;
      pend_pop  <= pend_pop_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_index <= rd_index_next;
    rsp      <= rsp_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count)) ||
                    (count == CW'($past(count) + 1'b1)) ||
                    (count == CW'($past(count) - 1'b1)))
    else $error("occupancy moved by more than one");

  a_sweep_no_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> !rsp_valid)
    else $error("response pending while read chain runs");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state not one-hot");
`endif

endmodule

### hw/rtl/deq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the queue row: a word plus one stage of the read chain.
module deq_cell #(
  parameter int IW    = 4,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  deq_pkg::ctrl_t     ctrl,
  input  logic [IW-1:0]      wr_index,
  input  logic [IW-1:0]      rd_index,
  input  logic [31:0]        fill,
  input  logic [31:0]        left_word,
  input  logic [31:0]        right_word,
  input  logic [31:0]        coll_in,
  output logic [31:0]        word,
  output logic [31:0]        coll_out
);

  always_ff @(posedge clk) begin
    if (ctrl.shift_up) begin
      word <= left_word;
    end else if (ctrl.shift_dn) begin
      word <= right_word;
    end else if (ctrl.write && (wr_index == IW'(INDEX))) begin
      word <= fill;
    end
  end

  // read chain: the selected cell injects its word, others pass the neighbor's
  always_ff @(posedge clk) begin
    coll_out <= (rd_index == IW'(INDEX)) ? word : coll_in;
  end

endmodule

### tb/tb_double_ended_queue_with_kth.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded double-ended queue with k-th-from-back read.
module tb_double_ended_queue_with_kth;

  localparam int QDEPTH = deq_pkg::DEPTH_DEF;
  localparam int QIW    = $clog2(QDEPTH);
  // Random commands that reach the block, not counting the unused codes
  localparam int unsigned RANDOM_ITEMS = 1450;
  // Longest quiet stretch allowed: a slow pop or k-th read keeps the block busy while the
  // read chain runs, and the receiver may stall on top of that.
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT = 10;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_ready;
  deq_pkg::cmd_t cmd = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  deq_pkg::rsp_t rsp;

  double_ended_queue_with_kth #(
    .DEPTH(QDEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Queue contents as the block should hold them. The ring keeps words by
  // physical slot; the flipped flag swaps which physical end is the logical
  // front, so reverse costs nothing but a toggle.
  // ---------------------------------------------------------------------------
  logic signed [31:0] ring_mem [QDEPTH];
  int unsigned        head_ptr = 0;
  int unsigned        live_cnt = 0;
  bit                 flipped  = 1'b0;

  deq_pkg::cmd_t pending_cmds[$];   // commands waiting for the driver
  deq_pkg::rsp_t expected_rsps[$];  // one response per accepted command, in order
  int unsigned   total_cmds    = 0;
  int unsigned   accepted_cmds = 0;
  int unsigned   rsp_seen      = 0;
  int unsigned   mismatches    = 0;
  int unsigned   quiet_cycles  = 0;
  int unsigned   gen_cnt       = 0;  // occupancy as the stimulus generator tracks it

  // Applies one command to the queue state and returns the response it must yield.
  function automatic deq_pkg::rsp_t deque_response(input deq_pkg::cmd_t c);
    deq_pkg::rsp_t r;
    r = '0;
    case (c.command)
      deq_pkg::CMD_PUSH_BACK, deq_pkg::CMD_PUSH_FRONT: begin
        if (live_cnt >= QDEPTH) begin
          r.error = deq_pkg::ERR_FULL;
        end else if ((c.command == deq_pkg::CMD_PUSH_BACK) != flipped) begin
          ring_mem[QIW'((head_ptr + live_cnt) % QDEPTH)] = c.value;
          live_cnt++;
        end else begin
          head_ptr = (head_ptr + QDEPTH - 1) % QDEPTH;
          ring_mem[QIW'(head_ptr)] = c.value;
          live_cnt++;
        end
      end
      deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
        if (live_cnt == 0) begin
          r.error = deq_pkg::ERR_EMPTY;
        end else if ((c.command == deq_pkg::CMD_POP_FRONT) != flipped) begin
          r.data = ring_mem[QIW'(head_ptr)];
          head_ptr = (head_ptr + 1) % QDEPTH;
          live_cnt--;
        end else begin
          r.data = ring_mem[QIW'((head_ptr + live_cnt - 1) % QDEPTH)];
          live_cnt--;
        end
      end
      deq_pkg::CMD_KTH: begin
        // empty is tested before the position
        if (live_cnt == 0) begin
          r.error = deq_pkg::ERR_EMPTY;
        end else if (c.position == 0 || c.position > live_cnt) begin
          r.error = deq_pkg::ERR_POS;
        end else if (flipped) begin
          r.data = ring_mem[QIW'((head_ptr + c.position - 1) % QDEPTH)];
        end else begin
          r.data = ring_mem[QIW'((head_ptr + live_cnt - c.position) % QDEPTH)];
        end
      end
      deq_pkg::CMD_REVERSE: begin
        flipped = !flipped;
      end
      default: begin
        // codes six and seven leave everything alone
      end
    endcase
    r.occupancy = 5'(live_cnt);
    return r;
  endfunction

  // Queues one command and keeps the generator's own occupancy estimate current.
  function automatic void queue_cmd(input logic [2:0] op, input logic [31:0] v,
                                    input logic [4:0] k);
    deq_pkg::cmd_t c;
    c.command  = op;
    c.value    = v;
    c.position = k;
    pending_cmds.push_back(c);
    if ((op == deq_pkg::CMD_PUSH_BACK || op == deq_pkg::CMD_PUSH_FRONT) && gen_cnt < QDEPTH)
      gen_cnt++;
    if ((op == deq_pkg::CMD_POP_FRONT || op == deq_pkg::CMD_POP_BACK) && gen_cnt > 0)
      gen_cnt--;
  endfunction

  // Idle pattern by thirds of the run: light sender gaps with heavy receiver
  // stalls, then the reverse, then full speed on both sides.
  function automatic int unsigned idle_pct(input bit sender);
    if (accepted_cmds * 3 < total_cmds) return sender ? 11 : 67;
    if (accepted_cmds * 3 < total_cmds * 2) return sender ? 67 : 11;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: the response is predicted at the command transfer edge, then the
  // next command (or a gap) is presented once the slot is free.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        expected_rsps.push_back(deque_response(cmd));
        accepted_cmds++;
      end
      if (!cmd_valid || cmd_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          cmd       <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each response transfer is matched against the oldest prediction.
  // Also keeps the quiet-cycle count for the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    deq_pkg::rsp_t want;
    if (rst) begin
      rsp_ready    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("rsp %0d: unexpected transfer, data %0d error %0d occupancy %0d",
                     rsp_seen, rsp.data, rsp.error, rsp.occupancy);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.data !== want.data || rsp.error !== want.error ||
              rsp.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("rsp %0d: expected data/error/occ %0d/%0d/%0d, got %0d/%0d/%0d",
                       rsp_seen, want.data, want.error, want.occupancy,
                       rsp.data, rsp.error, rsp.occupancy);
          end
        end
        rsp_seen++;
      end
      rsp_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: no transfer for too long means the block hung.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rnd_items;
    int unsigned mode;
    int unsigned roll;
    int unsigned p_push;
    int unsigned p_pop;
    logic [2:0]  op;
    logic [31:0] v;
    logic [4:0]  k;

    // Directed: errors on an empty queue, extreme words at both ends,
    // every k-th boundary, unused codes, and ends swapped by reverse.
    queue_cmd(deq_pkg::CMD_POP_FRONT,  32'h0000_1234, 5'd1);
    queue_cmd(deq_pkg::CMD_POP_BACK,   32'h0000_0000, 5'd0);
    queue_cmd(deq_pkg::CMD_KTH,        32'h0000_0000, 5'd1);   // empty wins over position
    queue_cmd(deq_pkg::CMD_REVERSE,    32'hFFFF_FFFF, 5'd31);  // toggle on empty, no effect
    queue_cmd(deq_pkg::CMD_REVERSE,    32'h0000_0000, 5'd0);
    queue_cmd(deq_pkg::CMD_PUSH_BACK,  32'h7FFF_FFFF, 5'd0);
    queue_cmd(deq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 5'd31);
    queue_cmd(deq_pkg::CMD_PUSH_BACK,  32'h0000_0000, 5'd16);
    queue_cmd(deq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF, 5'd0);
    queue_cmd(deq_pkg::CMD_KTH,        32'hDEAD_BEEF, 5'd0);   // position zero
    queue_cmd(deq_pkg::CMD_KTH,        32'h0000_0000, 5'd1);   // last word
    queue_cmd(deq_pkg::CMD_KTH,        32'h0000_0000, 5'd4);   // first word
    queue_cmd(deq_pkg::CMD_KTH,        32'h0000_0000, 5'd5);   // one past the count
    queue_cmd(deq_pkg::CMD_KTH,        32'h0000_0000, 5'd31);
    queue_cmd(3'd6,                    32'h1234_5678, 5'd3);   // unused codes: ignored
    queue_cmd(3'd7,                    32'hFFFF_FFFF, 5'd31);
    queue_cmd(deq_pkg::CMD_REVERSE,    32'h0000_0000, 5'd0);
    queue_cmd(deq_pkg::CMD_KTH,        32'h0000_0000, 5'd1);
    queue_cmd(deq_pkg::CMD_KTH,        32'h0000_0000, 5'd4);
    queue_cmd(deq_pkg::CMD_PUSH_BACK,  32'h5A5A_5A5A, 5'd0);   // lands at the physical front
    queue_cmd(deq_pkg::CMD_PUSH_FRONT, 32'hA5A5_A5A5, 5'd0);
    queue_cmd(deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 5'd0);
    queue_cmd(deq_pkg::CMD_POP_BACK,   32'h0000_0000, 5'd0);
    queue_cmd(deq_pkg::CMD_REVERSE,    32'h0000_0000, 5'd0);
    queue_cmd(deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 5'd0);

    // Random: stretches that lean toward filling or draining so the queue
    // keeps hitting full and empty, with balanced stretches in between.
    rnd_items = 0;
    mode      = 2;
    while (rnd_items < RANDOM_ITEMS) begin
      if (rnd_items % 48 == 0) mode = $urandom_range(0, 2);
      p_push = (mode == 0) ? 60 : (mode == 1) ? 15 : 38;
      p_pop  = (mode == 1) ? 60 : (mode == 0) ? 15 : 38;
      roll   = $urandom_range(0, 99);
      if (roll < p_push)
        op = $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
      else if (roll < p_push + p_pop)
        op = $urandom_range(0, 1) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_BACK;
      else if (roll < p_push + p_pop + 18)
        op = deq_pkg::CMD_KTH;
      else if (roll < p_push + p_pop + 23)
        op = deq_pkg::CMD_REVERSE;
      else
        op = 3'($urandom_range(6, 7));

      case ($urandom_range(0, 11))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = 32'hFFFF_FFFF;
        3:       v = 32'h0000_0000;
        default: v = $urandom;
      endcase

      if (op == deq_pkg::CMD_KTH && gen_cnt > 0 && $urandom_range(0, 99) < 80)
        k = 5'($urandom_range(1, gen_cnt));
      else
        k = 5'($urandom_range(0, 31));

      queue_cmd(op, v, k);
      if (op <= deq_pkg::CMD_REVERSE) rnd_items++;
    end
    total_cmds = pending_cmds.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || cmd_valid || expected_rsps.size() != 0)
      @(posedge clk);
    // let any stray response show up before the verdict
    repeat (QDEPTH + 4) @(posedge clk);

    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
